@@ hw/rtl/b64x_pkg.sv @@
package b64x_pkg;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_CIPHER_KEY = 1'd0;
  localparam logic [0:0] REG_DIRECTION  = 1'd1;

  // Direction codes.
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int MAX_RESULTS = 4;
  localparam int RES_CNT_W   = 3;
  localparam int RES_IDX_W   = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_message;
  } out_t;

  typedef out_t [MAX_RESULTS-1:0] res_list_t;

  typedef struct packed {
    logic [1:0]  group_phase;
    logic [11:0] bit_carry;
    logic [3:0]  carry_count;
    logic        pad_seen;
  } codec_state_t;

  typedef struct packed {
    logic [7:0] cipher_key;
    logic       direction;
  } codec_cfg_t;

endpackage

@@ hw/rtl/base64_case_swap_xor_codec_core.sv @@
// Base64 codec with letter case swap and key XOR, one message byte per transfer.
// Input channel: in_valid/in_ready carry in_data (data_byte plus a last flag).
// Output channel: out_valid/out_ready carry out_data (out_byte, has_byte and
// end_of_message); one input byte yields zero to four output transfers.
// Configuration: cfg_we with cfg_index 0 loads the cipher key, index 1 loads the
// direction (0 encrypt, 1 decrypt) and drops any message in progress. Write only
// while the block is idle.
// An accepted byte passes the input register and then the result buffer before
// its first result appears. Throughput: the result buffer drains one result per
// cycle while the receiver is ready; encoding averages four results per three
// bytes, decoding one result or none per byte.
// The input register accepts a new byte while the buffer still drains.
// If the receiver stalls, results wait in the buffer, one more byte waits in
// the input register, and in_ready then drops.
// Reset clears the key, the direction, the codec state and all buffered data.
module base64_case_swap_xor_codec_core import b64x_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Input register: holds one accepted byte until the step logic takes it.
  logic                 in_valid_r;
  in_t                  in_item_r;

  // Result buffer: the full result list of one byte, read out in order.
  res_list_t            buf_r;
  logic [RES_CNT_W-1:0] rem_r;
  logic [RES_IDX_W-1:0] idx_r;

  codec_state_t         state_r;
  codec_state_t         state_nxt;
  codec_cfg_t           cfg_r;
  res_list_t            results;
  logic [RES_CNT_W-1:0] res_count;

  logic                 buf_free;
  logic                 proc;
  logic                 out_fire;

  b64x_step u_step (
    .cfg       (cfg_r),
    .st        (state_r),
    .item      (in_item_r),
    .st_nxt    (state_nxt),
    .results   (results),
    .res_count (res_count)
  );

  // The buffer can take a new list when it is empty or its final entry leaves now.
  assign buf_free  = (rem_r == 3'd0) || (rem_r == 3'd1 && out_ready);
  assign proc      = in_valid_r && buf_free;
  assign in_ready  = !in_valid_r || proc;
  assign out_valid = (rem_r != 3'd0);
  assign out_data  = buf_r[idx_r];
  assign out_fire  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      rem_r      <= '0;
      idx_r      <= '0;
      state_r    <= '0;
      cfg_r      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (proc) begin
        in_valid_r <= 1'b0;
      end

      if (proc) begin
        rem_r   <= res_count;
        idx_r   <= '0;
        state_r <= state_nxt;
      end else if (out_fire) begin
        rem_r <= rem_r - 3'd1;
        idx_r <= idx_r + 2'd1;
      end

      // The user must send configuration only while idle; nothing here enforces it.
      if (cfg_we) begin
        case (cfg_index)
          REG_CIPHER_KEY: cfg_r.cipher_key <= cfg_wdata;
          REG_DIRECTION: begin
            cfg_r.direction <= cfg_wdata[0];
            state_r         <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (proc) begin
      buf_r <= results;
    end
  end

`ifndef ASSERT_OFF
  a_buf_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != 3'd0) |-> (({1'b0, idx_r} + rem_r) <= 3'd4))
    else $error("result buffer read past its list");

  a_eom_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_message) |-> (rem_r == 3'd1))
    else $error("end of message flagged before the final result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && in_item_r.last) |=> (state_r == '0))
    else $error("codec state not cleared after message end");

  a_enc_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_r.direction == DIR_ENCRYPT) |->
      (state_r.carry_count == 4'd0 || state_r.carry_count == 4'd2 ||
       state_r.carry_count == 4'd4))
    else $error("encoder carry count out of step");
`endif

endmodule

@@ hw/rtl/b64x_step.sv @@
module b64x_step import b64x_pkg::*; (
  input  codec_cfg_t            cfg,
  input  codec_state_t          st,
  input  in_t                   item,
  output codec_state_t          st_nxt,
  output res_list_t             results,
  output logic [RES_CNT_W-1:0]  res_count
);

  localparam logic [7:0] CHAR_PAD = 8'h3d;

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) begin
      return 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      return 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      return {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2b;
    end
    return 8'h2f;
  endfunction

  // Bit 6 flags a character of the alphabet; bits 5:0 carry its value.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      return {1'b1, 6'(c - 8'd65)};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      return {1'b1, 6'(c - 8'd71)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, 6'(c + 8'd4)};
    end else if (c == 8'h2b) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2f) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

  function automatic out_t enc_char(input logic [7:0] ch, input logic [7:0] key);
    out_t r;
    r.out_byte       = swap_case(ch) ^ key;
    r.has_byte       = 1'b1;
    r.end_of_message = 1'b0;
    return r;
  endfunction

  always_comb begin : step_logic
    logic [3:0]           cnt;
    logic [11:0]          car;
    logic [3:0]           sh;
    logic [1:0]           phase_n;
    logic [1:0]           pads;
    logic [7:0]           c;
    logic [6:0]           dv;
    logic [RES_CNT_W-1:0] n;
    logic [RES_CNT_W-1:0] last_idx;

    st_nxt   = st;
    results  = '0;
    n        = '0;
    cnt      = '0;
    car      = '0;
    sh       = '0;
    phase_n  = '0;
    pads     = '0;
    c        = '0;
    dv       = '0;
    last_idx = '0;

    if (cfg.direction == DIR_ENCRYPT) begin
      if (st.carry_count > 4'd4) begin
        cnt = 4'd0;
        car = 12'd0;
      end else begin
        cnt = st.carry_count;
        car = st.bit_carry;
      end
      car = {car[3:0], item.data_byte};
      cnt = cnt + 4'd8;

      // The first sextet always fits; a second one only when twelve bits are held.
      sh = cnt - 4'd6;
      results[n[RES_IDX_W-1:0]] = enc_char(sextet_char(6'(car >> sh)), cfg.cipher_key);
      n   = n + 3'd1;
      cnt = sh;
      car = car & ((12'd1 << cnt) - 12'd1);
      if (cnt >= 4'd6) begin
        sh = cnt - 4'd6;
        results[n[RES_IDX_W-1:0]] = enc_char(sextet_char(6'(car >> sh)), cfg.cipher_key);
        n   = n + 3'd1;
        cnt = sh;
        car = car & ((12'd1 << cnt) - 12'd1);
      end

      case (st.group_phase)
        2'd0:    phase_n = 2'd1;
        2'd1:    phase_n = 2'd2;
        2'd2:    phase_n = 2'd0;
        default: phase_n = 2'd1;
      endcase
      st_nxt.group_phase = phase_n;
      st_nxt.bit_carry   = car;
      st_nxt.carry_count = cnt;

      if (item.last) begin
        case (phase_n)
          2'd1:    pads = 2'd2;
          2'd2:    pads = 2'd1;
          default: pads = 2'd0;
        endcase
        if (cnt != 4'd0) begin
          results[n[RES_IDX_W-1:0]] =
            enc_char(sextet_char(6'(car << (4'd6 - cnt))), cfg.cipher_key);
          n = n + 3'd1;
        end
        if (pads >= 2'd1) begin
          results[n[RES_IDX_W-1:0]] = enc_char(CHAR_PAD, cfg.cipher_key);
          n = n + 3'd1;
        end
        if (pads >= 2'd2) begin
          results[n[RES_IDX_W-1:0]] = enc_char(CHAR_PAD, cfg.cipher_key);
          n = n + 3'd1;
        end
      end
    end else begin
      c  = swap_case(item.data_byte ^ cfg.cipher_key);
      dv = char_sextet(c);
      if (!st.pad_seen) begin
        if (c == CHAR_PAD) begin
          st_nxt.pad_seen = 1'b1;
        end else if (dv[6]) begin
          if (st.carry_count > 4'd6) begin
            cnt = 4'd0;
            car = 12'd0;
          end else begin
            cnt = st.carry_count;
            car = st.bit_carry;
          end
          car = {car[5:0], dv[5:0]};
          cnt = cnt + 4'd6;
          if (cnt >= 4'd8) begin
            sh = cnt - 4'd8;
            results[n[RES_IDX_W-1:0]].out_byte = 8'(car >> sh);
            results[n[RES_IDX_W-1:0]].has_byte = 1'b1;
            n   = n + 3'd1;
            cnt = sh;
            car = car & ((12'd1 << cnt) - 12'd1);
          end
          st_nxt.bit_carry   = car;
          st_nxt.carry_count = cnt;
        end
      end
      // A message end with nothing decoded still reports a bare end marker.
      if (item.last && n == 3'd0) begin
        n = 3'd1;
      end
    end

    if (item.last) begin
      last_idx = n - 3'd1;
      results[last_idx[RES_IDX_W-1:0]].end_of_message = 1'b1;
      st_nxt = '0;
    end

    res_count = n;
  end

endmodule

@@ tb/base64_case_swap_xor_codec_core_tb.sv @@
`timescale 1ns / 1ps

module base64_case_swap_xor_codec_core_tb;
  import b64x_pkg::*;

  // A taken byte passes the input register before its results appear. A byte
  // that yields nothing may still be in flight when the result queue runs dry,
  // so every settings change and the end of the run wait this many edges more.
  localparam int DRAIN_CYCLES = 12;
  localparam logic [7:0] PAD_CHAR = "=";

  // The scoreboard tracks the codec on its own. It keeps a private copy of the
  // key, the direction and the bit carry. Every accepted byte is turned into
  // the results it should cause, and those wait in order until the block
  // delivers them.
  class b64_codec_scoreboard;
    logic [7:0]  key_byte;
    logic        dir;
    logic [1:0]  group_pos;
    logic [11:0] carry;
    logic [3:0]  carry_bits;
    logic        pad_seen;
    out_t        pending_results[$];
    int          errors;
    int          bytes_in;
    int          results_out;

    function new();
      key_byte    = 8'h00;
      dir         = DIR_ENCRYPT;
      errors      = 0;
      bytes_in    = 0;
      results_out = 0;
      clear_message();
    endfunction

    function void clear_message();
      group_pos  = 2'd0;
      carry      = 12'd0;
      carry_bits = 4'd0;
      pad_seen   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_CIPHER_KEY) begin
        key_byte = val;
      end else if (idx == REG_DIRECTION) begin
        dir = val[0];
        clear_message();
      end
    endfunction

    function logic [7:0] flip_case(logic [7:0] c);
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
        return c ^ 8'h20;
      end
      return c;
    endfunction

    function logic [7:0] sextet_to_char(logic [5:0] v);
      int iv;
      iv = v;
      if (iv < 26) return 8'(int'("A") + iv);
      if (iv < 52) return 8'(int'("a") + iv - 26);
      if (iv < 62) return 8'(int'("0") + iv - 52);
      return (iv == 62) ? 8'("+") : 8'("/");
    endfunction

    function int char_to_sextet(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
    endfunction

    function void push_result(logic [7:0] b, logic has);
      out_t r;
      r.out_byte       = b;
      r.has_byte       = has;
      r.end_of_message = 1'b0;
      pending_results.push_back(r);
    endfunction

    // The newest result becomes the final one of the message.
    function void mark_end();
      out_t r;
      r = pending_results.pop_back();
      r.end_of_message = 1'b1;
      pending_results.push_back(r);
    endfunction

    function void note_input(in_t item);
      int unsigned cnt;
      int unsigned car;
      int unsigned pads;
      int          base;
      int          v;
      logic [7:0]  c;
      bytes_in++;
      base = pending_results.size();
      if (dir == DIR_ENCRYPT) begin
        cnt = carry_bits;
        car = carry;
        if (cnt > 4) begin
          cnt = 0;
          car = 0;
        end
        car = ((car << 8) | item.data_byte) & 32'hFFF;
        cnt += 8;
        while (cnt >= 6) begin
          push_result(flip_case(sextet_to_char(6'(car >> (cnt - 6)))) ^ key_byte, 1'b1);
          cnt -= 6;
          car &= (32'd1 << cnt) - 1;
        end
        group_pos  = (group_pos == 2'd2) ? 2'd0 : group_pos + 2'd1;
        carry      = car[11:0];
        carry_bits = cnt[3:0];
        if (item.last) begin
          // One leftover byte in the group takes two pad characters, two take one.
          pads = (group_pos == 2'd1) ? 2 : ((group_pos == 2'd2) ? 1 : 0);
          if (cnt > 0) begin
            push_result(flip_case(sextet_to_char(6'(car << (6 - cnt)))) ^ key_byte, 1'b1);
          end
          repeat (pads) push_result(PAD_CHAR ^ key_byte, 1'b1);
          mark_end();
          clear_message();
        end
      end else begin
        c = flip_case(item.data_byte ^ key_byte);
        if (!pad_seen) begin
          if (c == PAD_CHAR) begin
            pad_seen = 1'b1;
          end else begin
            v = char_to_sextet(c);
            if (v >= 0) begin
              cnt = carry_bits;
              car = carry;
              if (cnt > 6) begin
                cnt = 0;
                car = 0;
              end
              car = ((car << 6) | v) & 32'hFFF;
              cnt += 6;
              if (cnt >= 8) begin
                push_result(8'(car >> (cnt - 8)), 1'b1);
                cnt -= 8;
                car &= (32'd1 << cnt) - 1;
              end
              carry      = car[11:0];
              carry_bits = cnt[3:0];
            end
          end
        end
        if (item.last) begin
          // A message that ends without a decoded byte still gets an end marker.
          if (pending_results.size() == base) push_result(8'h00, 1'b0);
          mark_end();
          clear_message();
        end
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(out_t got);
      out_t want;
      results_out++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h has_byte %b end %b",
                                  got.out_byte, got.has_byte, got.end_of_message));
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("result %0d out_byte %h, wanted %h",
                                  results_out, got.out_byte, want.out_byte));
      if (got.has_byte !== want.has_byte)
        report_mismatch($sformatf("result %0d has_byte %b, wanted %b",
                                  results_out, got.has_byte, want.has_byte));
      if (got.end_of_message !== want.end_of_message)
        report_mismatch($sformatf("result %0d end_of_message %b, wanted %b",
                                  results_out, got.end_of_message, want.end_of_message));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Chance, in percent, that the sender pauses before a byte or that the
  // receiver holds off in a given cycle. The later test phases set both.
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // Bytes of the message that is about to be sent.
  logic [7:0] text_bytes[$];

  b64_codec_scoreboard sb = new();

  base64_case_swap_xor_codec_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Receiver side. The values seen here are the ones that held just before
  // the edge, so a result counts as transferred exactly when the block does.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Sends one byte, possibly after a short pause. Valid is kept high between
  // transfers when there is no pause, so it is never dropped and raised again
  // within the same edge.
  task automatic send_item(input logic [7:0] b, input logic is_last);
    in_t item;
    item.data_byte = b;
    item.last      = is_last;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  task automatic send_stream();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_item(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  // Sends base64 text as the decoder wants it: each character gets its case
  // swapped and is XORed with the key, so it comes out as plain text again.
  task automatic send_text(input string text, input logic [7:0] key);
    for (int i = 0; i < text.len(); i++) begin
      send_item(sb.flip_case(text[i]) ^ key, i == text.len() - 1);
    end
  endtask

  // Settings change only once the block has gone idle. Both registers are
  // loaded in two back-to-back writes. Writing the direction drops any
  // message that was left open.
  task automatic settle_and_load(input logic [7:0] key, input logic dir);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CIPHER_KEY;
    cfg_wdata <= key;
    @(posedge clk);
    sb.write_reg(REG_CIPHER_KEY, key);
    cfg_index <= REG_DIRECTION;
    cfg_wdata <= CFG_DATA_W'(dir);
    @(posedge clk);
    sb.write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
    cfg_we <= 1'b0;
  endtask

  // Builds a well-formed cipher text for the decoder from random plain bytes.
  // The text that encryption with a key produces is exactly what decryption
  // with the same key expects, so a private copy of the scoreboard, set to
  // encrypt, serves as the encoder.
  task automatic make_cipher_text(input logic [7:0] key, input int len);
    b64_codec_scoreboard enc;
    in_t  item;
    out_t r;
    enc = new();
    enc.write_reg(REG_CIPHER_KEY, key);
    enc.write_reg(REG_DIRECTION, CFG_DATA_W'(DIR_ENCRYPT));
    text_bytes.delete();
    for (int i = 0; i < len; i++) begin
      item.data_byte = 8'($urandom_range(255));
      item.last      = (i == len - 1);
      enc.note_input(item);
    end
    while (enc.pending_results.size() != 0) begin
      r = enc.pending_results.pop_front();
      text_bytes.push_back(r.out_byte);
    end
  endtask

  // Random traffic under one setting. Decoder traffic is mostly real cipher
  // text, which is the only way to reach the carry and padding states. Some
  // of it is damaged by stray characters, junk after the padding or a cut
  // end, and the rest is raw noise.
  task automatic run_random(input int n_items, input logic [7:0] key, input logic dir);
    int target;
    int len;
    int sel;
    settle_and_load(key, dir);
    target = sb.bytes_in + n_items;
    while (sb.bytes_in < target) begin
      text_bytes.delete();
      if (dir == DIR_ENCRYPT) begin
        len = $urandom_range(1, 10);
        repeat (len) text_bytes.push_back(8'($urandom_range(255)));
      end else begin
        sel = $urandom_range(99);
        if (sel < 75) begin
          make_cipher_text(key, $urandom_range(1, 9));
          if ($urandom_range(99) < 20)
            text_bytes.insert($urandom_range(text_bytes.size() - 1),
                              8'($urandom_range(255)));
          if ($urandom_range(99) < 15) text_bytes.push_back(8'($urandom_range(255)));
          if ($urandom_range(99) < 10 && text_bytes.size() > 1)
            text_bytes.delete(text_bytes.size() - 1);
        end else begin
          len = $urandom_range(1, 8);
          repeat (len) text_bytes.push_back(8'($urandom_range(255)));
        end
      end
      send_stream();
    end
    // Now and then a message is left open, and the next direction write drops it.
    if ($urandom_range(1) == 1) send_item(8'($urandom_range(255)), 1'b0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The first messages are a single byte of all zeros, two
    // bytes of all ones and a full group that maps to sextet 62 throughout.
    // A message is then left open so the direction write must drop it.
    settle_and_load(8'h00, DIR_ENCRYPT);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFB, 1'b0);
    send_item(8'hEF, 1'b0);
    send_item(8'hBE, 1'b1);
    send_item(8'h12, 1'b0);
    settle_and_load(8'hFF, DIR_ENCRYPT);
    send_item("M", 1'b1);

    // Decoder cases come next. A clean group is followed by padding with a
    // junk character after it. That junk is ignored, and because the final
    // byte decodes nothing, the message closes on a bare end marker. Stray
    // and non-ASCII characters are skipped, and leftover bits are dropped.
    // A lone non-alphabet character makes a message with no data at all.
    settle_and_load(8'hFF, DIR_DECRYPT);
    send_text("TWFu", 8'hFF);
    send_text("TQ==x", 8'hFF);
    send_item(sb.flip_case("#") ^ 8'hFF, 1'b0);
    send_item(8'hC3 ^ 8'hFF, 1'b0);
    send_text("QU", 8'hFF);
    send_text("!", 8'hFF);
    send_item(sb.flip_case("T") ^ 8'hFF, 1'b0);

    // Random part. Four idle patterns are used, each with both directions,
    // and the key is moved through both extremes and random values.
    run_random(65, 8'h00, DIR_ENCRYPT);
    run_random(65, 8'hFF, DIR_DECRYPT);

    in_idle_pct   = 57;
    out_stall_pct = 0;
    run_random(65, 8'($urandom_range(255)), DIR_ENCRYPT);
    run_random(65, 8'($urandom_range(255)), DIR_DECRYPT);

    in_idle_pct   = 0;
    out_stall_pct = 57;
    run_random(65, 8'hFF, DIR_ENCRYPT);
    run_random(65, 8'h00, DIR_DECRYPT);

    in_idle_pct   = 38;
    out_stall_pct = 38;
    run_random(65, 8'($urandom_range(255)), DIR_DECRYPT);
    run_random(65, 8'($urandom_range(255)), DIR_ENCRYPT);

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run summary: %0d bytes in, %0d results out, %0d mismatches.",
             sb.bytes_in, sb.results_out, sb.errors);
    $display("Both directions ran with keys 00, FF and random, under four idle patterns.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop in case the block hangs. A correct run needs only a small part
  // of this time.
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/b64x_pkg.sv
hw/rtl/b64x_step.sv
hw/rtl/base64_case_swap_xor_codec_core.sv
tb/base64_case_swap_xor_codec_core_tb.sv
